// File: rtl/omp_pkg.sv
// Shared constants, types and helper function of the order-preserving matcher.
`default_nettype none
package omp_pkg;

  localparam int MAX_PATTERNS = 1024;
  localparam int MAX_WINDOW   = 15;
  localparam int MAX_GRAM     = 10;
  localparam int VALUE_BITS   = 32;

  localparam int SLOT_W  = $clog2(MAX_PATTERNS);
  localparam int COUNT_W = $clog2(MAX_PATTERNS + 1);
  localparam int POS_W   = $clog2(MAX_WINDOW + 1);
  localparam int FP_W    = 22;
  localparam int FAC_W   = 19;
  localparam int SEEN_W  = 20;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_PREP = 2'd2;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_GRAM   = 2'd1;
  localparam logic [1:0] CFG_ACTIVE = 2'd2;

  typedef logic [MAX_WINDOW-1:0][VALUE_BITS-1:0] val_vec_t;

  typedef struct packed {
    logic [MAX_WINDOW-1:0] gt_row;
    logic [MAX_WINDOW-1:0] eq_row;
    logic [POS_W-1:0]      rank;
    logic                  eq_before;
    logic [POS_W-1:0]      gcnt;
  } cmp_res_t;

  typedef struct packed {
    logic [POS_W-1:0]                  len;
    logic [FP_W-1:0]                   fp;
    logic [MAX_WINDOW-1:0][POS_W-1:0]  spos;
    logic [MAX_WINDOW-1:0]             tie;
  } prep_row_t;

  function automatic logic [FAC_W-1:0] fac_weight(input logic [POS_W-1:0] d);
    logic [FAC_W-1:0] w;
    case (d)
      4'd1:    w = 19'd1;
      4'd2:    w = 19'd2;
      4'd3:    w = 19'd6;
      4'd4:    w = 19'd24;
      4'd5:    w = 19'd120;
      4'd6:    w = 19'd720;
      4'd7:    w = 19'd5040;
      4'd8:    w = 19'd40320;
      4'd9:    w = 19'd362880;
      default: w = 19'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/omp_cmp.sv
// Comparator bank: relates one selected value to every value of a row.
`default_nettype none
module omp_cmp (
  input  wire omp_pkg::val_vec_t       vals,
  input  wire logic [omp_pkg::POS_W-1:0] sel,
  input  wire logic [omp_pkg::POS_W-1:0] lim,
  input  wire logic [omp_pkg::POS_W-1:0] blk_lo,
  output omp_pkg::cmp_res_t            res
);

  always_comb begin
    logic signed [omp_pkg::VALUE_BITS-1:0] vi;
    logic signed [omp_pkg::VALUE_BITS-1:0] vj;
    logic gt;
    logic eq;
    res = '0;
    vi  = $signed(vals[sel]);
    for (int j = 0; j < omp_pkg::MAX_WINDOW; j++) begin
      vj = $signed(vals[j]);
      gt = vj > vi;
      eq = vj == vi;
      res.gt_row[j] = gt;
      res.eq_row[j] = eq;
      if (omp_pkg::POS_W'(j) < lim && omp_pkg::POS_W'(j) != sel) begin
        if (!gt && (!eq || omp_pkg::POS_W'(j) < sel)) begin
          res.rank = res.rank + 1'b1;
        end
      end
      if (omp_pkg::POS_W'(j) < sel && eq) begin
        res.eq_before = 1'b1;
      end
      if (omp_pkg::POS_W'(j) >= blk_lo && omp_pkg::POS_W'(j) < sel && !gt) begin
        res.gcnt = res.gcnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/multi_pattern_order_preserving_matcher.sv
// Top level of the multi-pattern order-preserving matcher with fingerprint filter.
// Input channel: in_tuser carries the opcode, in_tdata the slot, position and value.
// A load transfer writes one pattern element. A prepare transfer rebuilds the
// tables of all 1024 slots, each slot in turn by one value-row read, one length
// step, 15 rank steps through the shared comparator bank and one table write, and
// restarts the text. A text transfer shifts the window; once m values have
// arrived since restart it builds the window relation matrix and fingerprint,
// then walks the prepared table memory through its single read port at one cycle
// per active pattern, drains the check pipeline, and produces one result transfer
// on the output channel.
// The output register parts the two channels: while a result waits for out_tready
// the block keeps taking transfers; a search that finishes holds until the
// register is free. Configuration transfers are always taken; window and gram
// lengths take effect at the next prepare. After reset the window and counters
// are clear, m is 15 and q is 7; pattern tables hold no data until loaded and
// prepared.
`default_nettype none
module multi_pattern_order_preserving_matcher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // pattern_slot, element_position, value, zero pad
  input  wire  [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // window_start, window_matched, patterns_matched,
                                  // total_matches
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [10:0] cfg_data
);

  localparam int PW = omp_pkg::POS_W;
  localparam int SW = omp_pkg::SLOT_W;
  localparam int CW = omp_pkg::COUNT_W;
  localparam int MW = omp_pkg::MAX_WINDOW;
  localparam int FW = omp_pkg::FP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP_RD, S_PREP_LD, S_PREP_RANK, S_PREP_WR, S_TXT_BUILD, S_SRCH, S_DONE
  } state_t;

  state_t state_r;

  logic [PW-1:0] win_len_r, gram_len_r;
  logic [CW-1:0] active_r;
  logic [PW-1:0] held_m_r, held_q_r;

  logic [MW-1:0][omp_pkg::VALUE_BITS-1:0] row_mem [omp_pkg::MAX_PATTERNS];
  omp_pkg::prep_row_t prep_mem [omp_pkg::MAX_PATTERNS];
  omp_pkg::val_vec_t  val_rd_r;
  omp_pkg::prep_row_t prep_rd_r;

  omp_pkg::val_vec_t win_r;
  logic [omp_pkg::SEEN_W-1:0] seen_r;
  logic [PW-1:0] fill_r;
  logic [31:0]   total_r;

  logic [CW-1:0] slot_r;
  logic [PW-1:0] idx_r;
  logic [PW-1:0] len_r;
  logic [FW-1:0] fp_r;
  logic [MW-1:0][PW-1:0] spos_r;
  logic [MW-1:0] tie_r;
  logic [MW-1:0][MW-1:0] lt_mat_r, eq_mat_r;
  logic [CW-1:0] hits_r;
  logic chk_v_r, hit_v_r, hit_r;
  logic out_valid_r;
  logic [63:0] out_data_r;

  logic in_acc;
  logic [1:0] op;
  logic [SW-1:0] in_slot;
  logic [PW-1:0] in_pos;
  logic [omp_pkg::VALUE_BITS-1:0] in_val;
  logic [CW-1:0] n_act;
  logic [PW-1:0] m_clamp, q_clamp, fill_nxt;
  logic [PW-1:0] blk_lo, blk_hi, off, len_calc;
  logic text_phase;
  omp_pkg::val_vec_t cmp_vals;
  omp_pkg::cmp_res_t cmp_res;
  logic [FW-1:0] fp_term;
  logic chain_ok;

  assign in_tready  = state_r == S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_acc     = in_tvalid && in_tready;
  assign op         = in_tuser;
  assign in_slot    = in_tdata[9:0];
  assign in_pos     = in_tdata[13:10];
  assign in_val     = in_tdata[45:14];

  assign n_act = (active_r > CW'(omp_pkg::MAX_PATTERNS)) ? CW'(omp_pkg::MAX_PATTERNS) : active_r;

  always_comb begin
    m_clamp = (win_len_r == '0) ? PW'(1) : win_len_r;
    q_clamp = gram_len_r;
    if (q_clamp > PW'(omp_pkg::MAX_GRAM)) q_clamp = PW'(omp_pkg::MAX_GRAM);
    if (q_clamp > m_clamp) q_clamp = m_clamp;
    if (q_clamp == '0) q_clamp = PW'(1);
  end

  assign fill_nxt   = (fill_r < PW'(MW)) ? fill_r + 1'b1 : fill_r;
  assign text_phase = state_r == S_TXT_BUILD;
  assign blk_lo     = text_phase ? PW'(MW) - held_q_r : held_m_r - held_q_r;
  assign blk_hi     = text_phase ? PW'(MW) : held_m_r;
  assign cmp_vals   = text_phase ? win_r : val_rd_r;
  assign off        = PW'(MW) - held_m_r;

  always_comb begin
    len_calc = held_m_r;
    for (int i = MW - 1; i >= 0; i--) begin
      if (PW'(i) < held_m_r && $signed(val_rd_r[i]) <= 0) len_calc = PW'(i);
    end
  end

  omp_cmp u_cmp (
    .vals   (cmp_vals),
    .sel    (idx_r),
    .lim    (len_r),
    .blk_lo (blk_lo),
    .res    (cmp_res)
  );

  assign fp_term = (idx_r >= blk_lo && idx_r < blk_hi)
                 ? FW'(cmp_res.gcnt) * FW'(omp_pkg::fac_weight(idx_r - blk_lo)) : '0;

  always_comb begin
    logic [PW-1:0] a, b;
    chain_ok = 1'b1;
    for (int k = 0; k < MW - 1; k++) begin
      a = prep_rd_r.spos[k] + off;
      b = prep_rd_r.spos[k+1] + off;
      if (PW'(k + 1) < prep_rd_r.len) begin
        if (prep_rd_r.tie[k] ? !eq_mat_r[a][b] : !lt_mat_r[a][b]) chain_ok = 1'b0;
      end
    end
  end

  // Memories: pattern values by slot row, prepared tables by slot.
  always_ff @(posedge clk) begin
    if (in_acc && op == omp_pkg::OP_LOAD && in_pos < PW'(MW)) begin
      row_mem[in_slot][in_pos] <= in_val;
    end
    val_rd_r <= row_mem[slot_r[SW-1:0]];
    if (state_r == S_PREP_WR) begin
      prep_mem[slot_r[SW-1:0]] <= '{len: len_r, fp: fp_r, spos: spos_r, tie: tie_r};
    end
    prep_rd_r <= prep_mem[slot_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_len_r   <= PW'(15);
      gram_len_r  <= PW'(7);
      active_r    <= '0;
      held_m_r    <= PW'(15);
      held_q_r    <= PW'(7);
      win_r       <= '0;
      seen_r      <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      chk_v_r     <= 1'b0;
      hit_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          omp_pkg::CFG_WINDOW: win_len_r  <= cfg_data[PW-1:0];
          omp_pkg::CFG_GRAM:   gram_len_r <= cfg_data[PW-1:0];
          omp_pkg::CFG_ACTIVE: active_r   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      chk_v_r <= state_r == S_SRCH && slot_r < n_act;
      hit_v_r <= chk_v_r;
      hit_r   <= chk_v_r && prep_rd_r.fp == fp_r && chain_ok;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (op)
              omp_pkg::OP_PREP: begin
                held_m_r <= m_clamp;
                held_q_r <= q_clamp;
                slot_r   <= '0;
                state_r  <= S_PREP_RD;
              end
              omp_pkg::OP_TEXT: begin
                for (int j = 0; j < MW - 1; j++) win_r[j] <= win_r[j+1];
                win_r[MW-1] <= in_val;
                seen_r      <= seen_r + 1'b1;
                fill_r      <= fill_nxt;
                idx_r       <= '0;
                fp_r        <= '0;
                if (fill_nxt >= held_m_r) state_r <= S_TXT_BUILD;
              end
              default: ;
            endcase
          end
        end
        S_PREP_RD: state_r <= S_PREP_LD;
        S_PREP_LD: begin
          len_r   <= len_calc;
          idx_r   <= '0;
          fp_r    <= '0;
          spos_r  <= '0;
          tie_r   <= '0;
          state_r <= S_PREP_RANK;
        end
        S_PREP_RANK: begin
          if (idx_r < len_r) begin
            spos_r[cmp_res.rank] <= idx_r;
            if (cmp_res.eq_before) tie_r[cmp_res.rank - 1'b1] <= 1'b1;
          end
          fp_r  <= fp_r + fp_term;
          idx_r <= idx_r + 1'b1;
          if (idx_r == PW'(MW - 1)) state_r <= S_PREP_WR;
        end
        S_PREP_WR: begin
          if (slot_r[SW-1:0] == SW'(omp_pkg::MAX_PATTERNS - 1)) begin
            win_r   <= '0;
            seen_r  <= '0;
            fill_r  <= '0;
            total_r <= '0;
            slot_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_PREP_RD;
          end
        end
        S_TXT_BUILD: begin
          lt_mat_r[idx_r] <= cmp_res.gt_row;
          eq_mat_r[idx_r] <= cmp_res.eq_row;
          fp_r  <= fp_r + fp_term;
          idx_r <= idx_r + 1'b1;
          if (idx_r == PW'(MW - 1)) begin
            slot_r  <= '0;
            hits_r  <= '0;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (slot_r < n_act) slot_r <= slot_r + 1'b1;
          if (hit_v_r && hit_r) begin
            hits_r <= hits_r + 1'b1;
            if (total_r != 32'hFFFF_FFFF) total_r <= total_r + 1'b1;
          end
          if (slot_r >= n_act && !chk_v_r && !hit_v_r) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {total_r, hits_r, hits_r != '0,
                            seen_r - omp_pkg::SEEN_W'(held_m_r)};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_pm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[31:21] <= CW'(omp_pkg::MAX_PATTERNS))
    else $error("Match count exceeds the pattern table.");

  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[20] == (out_data_r[31:21] != '0)))
    else $error("Match flag disagrees with the match count.");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> slot_r <= n_act)
    else $error("Table walk ran past the active patterns.");

  a_prep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == omp_pkg::OP_PREP) |=> !in_tready)
    else $error("Input taken while tables are being rebuilt.");

endmodule
`default_nettype wire
